[sv/wrm_pkg.sv]
// ----------------------------------------------------------------------------
// wrm_pkg
// Shared constants and types of the wildcard pattern matcher.
// ----------------------------------------------------------------------------
package wrm_pkg;

  localparam int MAX_PATTERN = 16;
  localparam int REG_BYTES   = 16;
  localparam int LEN_CAP     = (MAX_PATTERN < REG_BYTES) ? MAX_PATTERN : REG_BYTES;
  localparam int NUM_CELLS   = LEN_CAP;
  localparam int ROW_W       = NUM_CELLS + 1;
  localparam int LEN_W       = $clog2(ROW_W);
  localparam int PAT_W       = 8 * REG_BYTES;
  localparam int CFG_W       = 64;
  localparam int CFG_IDX_W   = 2;
  localparam int LEN_REG_W   = 5;

  localparam logic [7:0] STAR_CH = 8'h2A;
  localparam logic [7:0] DOT_CH  = 8'h2E;

  localparam logic [CFG_IDX_W-1:0] CFG_PAT_LOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PAT_HIGH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PAT_LEN  = 2'd2;

  typedef struct packed {
    logic [7:0] pat;
    logic       d;
    logic       n;
    logic       s;
    logic       n_prev;
    logic       s_prev;
    logic       live;
  } wrm_link_t;

endpackage

[sv/wrm_if.sv]
// ----------------------------------------------------------------------------
// wrm_if
// Handshake channels for text words in and verdict words out.
// ----------------------------------------------------------------------------
interface wrm_text_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       text_end;

  modport source (output valid, output text_byte, output text_end, input ready);
  modport sink   (input valid, input text_byte, input text_end, output ready);
endinterface

interface wrm_result_if;
  logic valid;
  logic ready;
  logic matched;

  modport source (output valid, output matched, input ready);
  modport sink   (input valid, input matched, output ready);
endinterface

[sv/wrm_cell.sv]
// ----------------------------------------------------------------------------
// wrm_cell
// One pattern position: holds its prefix-match bit and computes the start
// bit and the next bit from its own pattern byte and its left neighbor.
// ----------------------------------------------------------------------------
module wrm_cell import wrm_pkg::*; (
  input  logic       clk_i,
  input  logic [7:0] pat_i,
  input  logic       restart_i,
  input  logic       step_i,
  input  logic [7:0] text_byte_i,
  input  wrm_link_t  link_i,
  output wrm_link_t  link_o
);

  logic row_q, row_d;
  logic is_star, hit_own, hit_prev;
  logic s_bit, d_bit, n_bit;

  always_comb begin
    is_star  = (pat_i == STAR_CH);
    hit_own  = (pat_i == DOT_CH) || (pat_i == text_byte_i);
    hit_prev = (link_i.pat == DOT_CH) || (link_i.pat == text_byte_i);
    s_bit    = is_star && link_i.live && link_i.s_prev;
    d_bit    = restart_i ? s_bit : row_q;
    if (is_star) begin
      n_bit = link_i.live && (link_i.n_prev || (d_bit && hit_prev));
    end else begin
      n_bit = link_i.d && hit_own;
    end
    row_d = step_i ? n_bit : row_q;
  end

  always_ff @(posedge clk_i) begin
    row_q <= row_d;
  end

  always_comb begin
    link_o.pat    = pat_i;
    link_o.d      = d_bit;
    link_o.n      = n_bit;
    link_o.s      = s_bit;
    link_o.n_prev = link_i.n;
    link_o.s_prev = link_i.s;
    link_o.live   = 1'b1;
  end

endmodule

[sv/wildcard_regex_matcher_unit.sv]
// ----------------------------------------------------------------------------
// wildcard_regex_matcher_unit
// An end word's verdict is registered and shown in the cycle after acceptance.
// Throughput: one text word per cycle, set by the registered update of the row
// of match cells; a verdict held by a stalled receiver blocks input until it is
// taken. Reset clears the pattern and starts from the empty text.
// ----------------------------------------------------------------------------
module wildcard_regex_matcher_unit import wrm_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  wrm_text_if.sink             text_i,
  wrm_result_if.source         result_o
);

  logic [CFG_W-1:0]     pat_low_q, pat_high_q;
  logic [LEN_REG_W-1:0] len_q;
  logic                 restart_q, restart_d;
  logic                 out_valid_q, matched_q;
  logic                 cfg_hit, accept, step, fin;
  logic [PAT_W-1:0]     pattern;
  logic [LEN_W-1:0]     eff_len;
  logic [ROW_W-1:0]     d_vec;
  wrm_link_t            link [ROW_W];

  assign pattern = {pat_high_q, pat_low_q};
  assign eff_len = (len_q > LEN_REG_W'(LEN_CAP)) ? LEN_W'(LEN_CAP) : LEN_W'(len_q);

  always_comb begin
    unique case (cfg_idx_i) inside
      CFG_PAT_LOW, CFG_PAT_HIGH, CFG_PAT_LEN: cfg_hit = cfg_we_i;
      default:                                cfg_hit = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_low_q  <= '0;
      pat_high_q <= '0;
      len_q      <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_PAT_LOW:  pat_low_q  <= cfg_wdata_i;
        CFG_PAT_HIGH: pat_high_q <= cfg_wdata_i;
        CFG_PAT_LEN:  len_q      <= cfg_wdata_i[LEN_REG_W-1:0];
        default: ;
      endcase
    end
  end

  assign text_i.ready = !out_valid_q || result_o.ready;
  assign accept       = text_i.valid && text_i.ready;
  assign step         = accept && !text_i.text_end;
  assign fin          = accept && text_i.text_end;

  always_comb begin
    link[0].pat    = '0;
    link[0].d      = restart_q;
    link[0].n      = 1'b0;
    link[0].s      = 1'b1;
    link[0].n_prev = 1'b0;
    link[0].s_prev = 1'b0;
    link[0].live   = 1'b0;
  end

  for (genvar j = 1; j < ROW_W; j++) begin : g_cell
    wrm_cell u_cell (
      .clk_i       (clk_i),
      .pat_i       (pattern[(j-1)*8 +: 8]),
      .restart_i   (restart_q),
      .step_i      (step),
      .text_byte_i (text_i.text_byte),
      .link_i      (link[j-1]),
      .link_o      (link[j])
    );
  end

  for (genvar j = 0; j < ROW_W; j++) begin : g_row
    assign d_vec[j] = link[j].d;
  end

  always_comb begin
    restart_d = restart_q;
    if (cfg_hit || fin) begin
      restart_d = 1'b1;
    end else if (step) begin
      restart_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      restart_q   <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      restart_q <= restart_d;
      if (fin) begin
        out_valid_q <= 1'b1;
      end else if (result_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin) begin
      matched_q <= d_vec[eff_len];
    end
  end

  assign result_o.valid   = out_valid_q;
  assign result_o.matched = matched_q;

  a_fin_gives_verdict : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin |=> out_valid_q && restart_q)
    else $error("end word did not raise a verdict and restart the row");

  a_step_clears_restart : assert property (@(posedge clk_i) disable iff (!rst_ni)
    step && !cfg_hit |=> !restart_q)
    else $error("text word did not leave the start row");

  a_no_overwrite : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin && out_valid_q |-> result_o.ready)
    else $error("pending verdict overwritten");

endmodule
